// ===== rtl/qdx_pkg.sv =====
// qdx_pkg: shared types and constants for the x4 quadrature decoder with index
// no dependencies; used by every module under rtl

package qdx_pkg;

    // parameter defaults
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int FILTER_WIDTH_DEF = 10;

    // configuration register widths
    localparam int FS_W       = 10;
    localparam int DEG_W      = 23;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 23;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_SAMPLES    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEGREES_PER_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INDEX_ENABLE      = 2'd2;

    // configuration reset values
    localparam logic [FS_W-1:0]  FILTER_SAMPLES_RST    = 10'd100;
    localparam logic [DEG_W-1:0] DEGREES_PER_COUNT_RST = 23'd5898240;

    // one pin sample as it sits in the input tdata, lowest bit last in the list
    typedef struct packed {
        logic flag_ack;
        logic index_z;
        logic phase_b;
        logic phase_a;
    } qdx_sample_t;

    localparam int IN_DATA_W = 8;

endpackage

// ===== rtl/quadrature_x4_decoder_index_top.sv =====
// x4 quadrature decoder with index: the input stage (filters and count) registers its result
// and feeds the multiplier stage with its result register; throughput one beat per cycle
// while m_tready does not hold the output back.
// aresetn is synchronous, active low: count, flag, filters and registers return to
// their defaults (filter 100 samples, 90 degrees per count, index disabled).
// depends on qdx_pkg, qdx_track, qdx_angle

module quadrature_x4_decoder_index_top #(
    parameter int COUNT_WIDTH  = qdx_pkg::COUNT_WIDTH_DEF,
    parameter int FILTER_WIDTH = qdx_pkg::FILTER_WIDTH_DEF,
    localparam int ANG_W       = COUNT_WIDTH + qdx_pkg::DEG_W,
    localparam int OUT_BITS    = COUNT_WIDTH + ANG_W + 1,
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [qdx_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [qdx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // phase_a, phase_b, index_z, flag_ack, zero fill
    input  logic [qdx_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // position_count, angle_q16, index_seen, zero fill
    output logic [OUT_W-1:0]               m_tdata
);

    logic [qdx_pkg::FS_W-1:0]  filter_samples_reg;
    logic [qdx_pkg::DEG_W-1:0] degrees_per_count_reg;
    logic                      index_enable_reg;

    qdx_pkg::qdx_sample_t      sample;
    logic                      mid_valid;
    logic                      mid_ready;
    logic [COUNT_WIDTH-1:0]    mid_count;
    logic                      mid_flag;
    logic [COUNT_WIDTH-1:0]    out_count;
    logic [ANG_W-1:0]          out_angle;
    logic                      out_flag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_samples_reg    <= qdx_pkg::FILTER_SAMPLES_RST;
            degrees_per_count_reg <= qdx_pkg::DEGREES_PER_COUNT_RST;
            index_enable_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                qdx_pkg::REG_FILTER_SAMPLES: begin
                    filter_samples_reg <= cfg_wdata[qdx_pkg::FS_W-1:0];
                end
                qdx_pkg::REG_DEGREES_PER_COUNT: begin
                    degrees_per_count_reg <= cfg_wdata[qdx_pkg::DEG_W-1:0];
                end
                qdx_pkg::REG_INDEX_ENABLE: begin
                    index_enable_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign sample = qdx_pkg::qdx_sample_t'(s_tdata[3:0]);

    qdx_track #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .FILTER_WIDTH (FILTER_WIDTH)
    ) u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_sample      (sample),
        .filter_samples (filter_samples_reg),
        .index_enable   (index_enable_reg),
        .res_valid      (mid_valid),
        .res_ready      (mid_ready),
        .res_count      (mid_count),
        .res_flag       (mid_flag)
    );

    qdx_angle #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_angle (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (mid_valid),
        .in_ready          (mid_ready),
        .in_count          (mid_count),
        .in_flag           (mid_flag),
        .degrees_per_count (degrees_per_count_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_count         (out_count),
        .out_angle         (out_angle),
        .out_flag          (out_flag)
    );

    assign m_tdata = OUT_W'({out_flag, out_angle, out_count});

endmodule

// ===== rtl/qdx_filter.sv =====
// qdx_filter: glitch filter for one encoder line, holds the filtered level
// depends on qdx_pkg

module qdx_filter #(
    parameter int FILTER_WIDTH = qdx_pkg::FILTER_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  logic                     raw,
    input  logic [qdx_pkg::FS_W-1:0] filter_samples,
    output logic                     level,
    output logic                     accept
);

    localparam int CMP_W = (FILTER_WIDTH > qdx_pkg::FS_W) ? FILTER_WIDTH : qdx_pkg::FS_W;
    localparam logic [FILTER_WIDTH-1:0] RUN_MAX = {FILTER_WIDTH{1'b1}};

    logic                    level_reg;
    logic [FILTER_WIDTH-1:0] run_reg;
    logic [FILTER_WIDTH-1:0] run_next;
    logic [FILTER_WIDTH-1:0] run_inc;

    always_comb begin
        run_inc  = (run_reg == RUN_MAX) ? run_reg : run_reg + FILTER_WIDTH'(1);
        accept   = 1'b0;
        run_next = '0;
        if (raw != level_reg) begin
            if ((CMP_W'(run_inc) >= CMP_W'(filter_samples)) || (run_inc == RUN_MAX)) begin
                accept = 1'b1;
            end else begin
                run_next = run_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            run_reg   <= '0;
        end else if (fire) begin
            run_reg <= run_next;
            if (accept) begin
                level_reg <= raw;
            end
        end
    end

    assign level = level_reg;

endmodule

// ===== rtl/qdx_track.sv =====
// qdx_track: input stage, filters A and B, steps the position count, index flag
// depends on qdx_pkg and qdx_filter

module qdx_track #(
    parameter int COUNT_WIDTH  = qdx_pkg::COUNT_WIDTH_DEF,
    parameter int FILTER_WIDTH = qdx_pkg::FILTER_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  qdx_pkg::qdx_sample_t     in_sample,
    input  logic [qdx_pkg::FS_W-1:0] filter_samples,
    input  logic                     index_enable,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [COUNT_WIDTH-1:0]   res_count,
    output logic                     res_flag
);

    logic                   in_fire;
    logic                   acc_a;
    logic                   acc_b;
    logic                   level_a;
    logic                   level_b;
    logic                   idx_rise;
    logic                   flag_seen;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   flag_reg;
    logic                   prev_z_reg;
    logic                   res_valid_reg;
    logic                   res_flag_reg;

    assign in_ready = !res_valid_reg || res_ready;
    assign in_fire  = in_valid && in_ready;

    qdx_filter #(.FILTER_WIDTH(FILTER_WIDTH)) u_filter_a (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (in_fire),
        .raw            (in_sample.phase_a),
        .filter_samples (filter_samples),
        .level          (level_a),
        .accept         (acc_a)
    );

    qdx_filter #(.FILTER_WIDTH(FILTER_WIDTH)) u_filter_b (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (in_fire),
        .raw            (in_sample.phase_b),
        .filter_samples (filter_samples),
        .level          (level_b),
        .accept         (acc_b)
    );

    always_comb begin
        count_next = count_reg;
        // both lines moving at once is an illegal transition, count holds
        if (acc_a && !acc_b) begin
            if (in_sample.phase_a != level_b) begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end else begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end else if (acc_b && !acc_a) begin
            if (in_sample.phase_b == level_a) begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end else begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
        idx_rise = index_enable && in_sample.index_z && !prev_z_reg;
        if (idx_rise) begin
            count_next = '0;
        end
        flag_seen = flag_reg || idx_rise;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            prev_z_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                res_valid_reg <= in_valid;
            end
            if (in_fire) begin
                count_reg  <= count_next;
                flag_reg   <= flag_seen && !in_sample.flag_ack;
                prev_z_reg <= in_sample.index_z;
            end
        end
    end

    // reported flag is taken before the ack clears it
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_flag_reg <= flag_seen;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_count = count_reg;
    assign res_flag  = res_flag_reg;

    a_index_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && idx_rise |=> (count_reg == '0) && res_flag_reg)
        else $error("index edge did not clear count and report flag");

    a_both_lines_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && acc_a && acc_b && !idx_rise |=> count_reg == $past(count_reg))
        else $error("count moved on simultaneous A and B edges");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> $stable(count_reg) && $stable(flag_reg))
        else $error("state changed without an input beat");

    a_ack_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_sample.flag_ack |=> !flag_reg)
        else $error("acknowledge did not clear the index flag");

endmodule

// ===== rtl/qdx_angle.sv =====
// qdx_angle: output stage, multiplies count by degrees per count into the result register
// depends on qdx_pkg

module qdx_angle #(
    parameter int COUNT_WIDTH = qdx_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [COUNT_WIDTH-1:0]                     in_count,
    input  logic                                       in_flag,
    input  logic [qdx_pkg::DEG_W-1:0]                  degrees_per_count,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [COUNT_WIDTH-1:0]                     out_count,
    output logic [COUNT_WIDTH+qdx_pkg::DEG_W-1:0]      out_angle,
    output logic                                       out_flag
);

    localparam int ANG_W = COUNT_WIDTH + qdx_pkg::DEG_W;

    logic                       out_valid_reg;
    logic [COUNT_WIDTH-1:0]     count_reg;
    logic [ANG_W-1:0]           angle_reg;
    logic                       flag_reg;
    logic signed [ANG_W:0]      product;

    // degrees per count is unsigned, so it gets a zero sign bit
    assign product  = $signed(in_count) * $signed({1'b0, degrees_per_count});
    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            count_reg <= in_count;
            angle_reg <= product[ANG_W-1:0];
            flag_reg  <= in_flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_count = count_reg;
    assign out_angle = angle_reg;
    assign out_flag  = flag_reg;

endmodule

// ===== tb/quadrature_x4_decoder_index_top_tb.sv =====
// testbench for quadrature_x4_decoder_index_top: encoder pin samples go in as beats,
// and a local decoder model predicts the count, angle and index flag of each result
// depends on qdx_pkg and the rtl under rtl

module quadrature_x4_decoder_index_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW      = qdx_pkg::COUNT_WIDTH_DEF;
    localparam int FW      = qdx_pkg::FILTER_WIDTH_DEF;
    localparam int ANGLE_W = CW + qdx_pkg::DEG_W;
    localparam int OUT_W   = ((CW + ANGLE_W + 1 + 7) / 8) * 8;
    localparam logic [FW-1:0]             RUN_MAX = {FW{1'b1}};
    localparam logic [qdx_pkg::DEG_W-1:0] DEG_MAX = 23'd5898240;
    localparam logic [qdx_pkg::FS_W-1:0]  FS_MAX  = 10'd1023;

    // packed from the top bit down: flag, angle, count (count sits in the lowest bits)
    typedef struct packed {
        logic                 seen;
        logic [ANGLE_W-1:0]   angle;
        logic signed [CW-1:0] pos;
    } reading_t;

    typedef struct packed {
        logic          take;
        logic [FW-1:0] run;
    } filt_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [qdx_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [qdx_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [qdx_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [OUT_W-1:0]               m_tdata;

    quadrature_x4_decoder_index_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // decoder model state and its copy of the registers
    logic [qdx_pkg::FS_W-1:0]  fs_cfg = qdx_pkg::FILTER_SAMPLES_RST;
    logic [qdx_pkg::DEG_W-1:0] deg_cfg = qdx_pkg::DEGREES_PER_COUNT_RST;
    logic                      idx_en = 1'b0;
    logic                      filt_a = 1'b0;
    logic                      filt_b = 1'b0;
    logic [FW-1:0]             run_a = '0;
    logic [FW-1:0]             run_b = '0;
    logic signed [CW-1:0]      count = '0;
    logic                      prev_z = 1'b0;
    logic                      flag = 1'b0;

    qdx_pkg::qdx_sample_t pin_q[$];
    reading_t             reading_q[$];

    int  mism = 0;
    int  n_pushed = 0;
    bit  idling_on = 1'b1;
    bit  s_took = 1'b0;
    int  src_idle = 0;
    int  sink_idle = 0;
    int  sink_hold = 0;
    int  gen_code = 0;

    function automatic filt_t filter_line(logic raw, logic level, logic [FW-1:0] run);
        filt_t f;
        logic [FW-1:0] nxt;
        f.take = 1'b0;
        f.run  = '0;
        if (raw != level) begin
            nxt = run;
            if (nxt < RUN_MAX) nxt = nxt + 1'b1;
            // accepted once the run reaches the setting or the counter tops out
            if (nxt >= fs_cfg || nxt == RUN_MAX) f.take = 1'b1;
            else f.run = nxt;
        end
        return f;
    endfunction

    function automatic reading_t decode_sample(qdx_pkg::qdx_sample_t smp);
        filt_t    fa;
        filt_t    fb;
        logic     new_a;
        logic     new_b;
        longint   prod;
        reading_t r;
        fa = filter_line(smp.phase_a, filt_a, run_a);
        fb = filter_line(smp.phase_b, filt_b, run_b);
        run_a = fa.run;
        run_b = fb.run;
        new_a = fa.take ? smp.phase_a : filt_a;
        new_b = fb.take ? smp.phase_b : filt_b;
        // both lines moving in one sample is not a valid step and leaves the count alone
        if (fa.take && !fb.take) begin
            count = (new_a != filt_b) ? count + CW'(1) : count - CW'(1);
        end else if (fb.take && !fa.take) begin
            count = (new_b == filt_a) ? count + CW'(1) : count - CW'(1);
        end
        filt_a = new_a;
        filt_b = new_b;
        if (idx_en && smp.index_z && !prev_z) begin
            count = '0;
            flag  = 1'b1;
        end
        prev_z = smp.index_z;
        prod = longint'(count) * longint'(deg_cfg);
        r.pos   = count;
        r.angle = prod[ANGLE_W-1:0];
        r.seen  = flag;
        if (smp.flag_ack) flag = 1'b0;
        return r;
    endfunction

    // input side: beats go out at the falling edge
    always @(negedge aclk) begin
        logic                          nxt_valid;
        logic [qdx_pkg::IN_DATA_W-1:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_took) begin
                s_took    = 1'b0;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_idle > 0) begin
                    src_idle = src_idle - 1;
                end else if (pin_q.size() > 0) begin
                    if (idling_on && $urandom_range(0, 9) == 0) begin
                        src_idle = $urandom_range(1, 14) - 1;
                    end else begin
                        nxt_data  = {{(qdx_pkg::IN_DATA_W - 4){1'b0}}, pin_q.pop_front()};
                        nxt_valid = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            reading_q.push_back(decode_sample(qdx_pkg::qdx_sample_t'(s_tdata[3:0])));
            s_took = 1'b1;
        end
    end

    // result side: ready changes at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end else if (sink_idle > 0) begin
            sink_idle = sink_idle - 1;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 11) == 0) begin
            sink_idle = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = reading_t'(m_tdata[CW + ANGLE_W:0]);
            if (reading_q.size() == 0) begin
                mism = mism + 1;
                if (mism <= 10)
                    $display("result beat with nothing pending: count %0d angle %0d flag %0b",
                             got.pos, $signed(got.angle), got.seen);
            end else begin
                want = reading_q.pop_front();
                if (got !== want) begin
                    mism = mism + 1;
                    if (mism <= 10)
                        $display("mismatch: count exp %0d got %0d, angle exp %0d got %0d, %s%0b got %0b",
                                 want.pos, got.pos, $signed(want.angle), $signed(got.angle),
                                 "flag exp ", want.seen, got.seen);
                end
            end
        end
    end

    task automatic push_pins(int a, int b, int z, int ack);
        qdx_pkg::qdx_sample_t smp;
        smp.phase_a  = a[0];
        smp.phase_b  = b[0];
        smp.index_z  = z[0];
        smp.flag_ack = ack[0];
        pin_q.push_back(smp);
        n_pushed = n_pushed + 1;
    endtask

    // move along the quadrature cycle 00, 10, 11, 01 and send one sample
    task automatic pin_step(int delta, int z, int ack);
        gen_code = (gen_code + delta + 4) % 4;
        push_pins((gen_code ^ (gen_code >> 1)) & 1, (gen_code >> 1) & 1, z, ack);
    endtask

    task automatic push_level(int n, inout logic z);
        int g;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0) z = ~z;
            g = (gen_code[0] ^ gen_code[1]) | (gen_code[1] << 1);
            // a lone glitch on one line now and then
            if ($urandom_range(0, 39) == 0) g = g ^ (1 << $urandom_range(0, 1));
            push_pins(g & 1, (g >> 1) & 1, int'(z), int'($urandom_range(0, 5) == 0));
        end
    endtask

    task automatic run_encoder(int steps, int fs);
        int   dir;
        int   hold;
        int   kind;
        logic z;
        dir  = 1;
        z    = 1'b0;
        hold = (fs < 1) ? 1 : fs;
        for (int i = 0; i < steps; i++) begin
            kind = $urandom_range(0, 19);
            if ($urandom_range(0, 7) == 0) dir = -dir;
            if (kind == 0) begin
                repeat ($urandom_range(1, 6))
                    push_pins($urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (kind == 1) begin
                gen_code = (gen_code + 2) % 4;
            end else if (kind == 2 && fs >= 2) begin
                // level drops back one sample short of the filter setting
                gen_code = (gen_code + dir + 4) % 4;
                push_level(fs - 1, z);
                gen_code = (gen_code - dir + 4) % 4;
            end else begin
                gen_code = (gen_code + dir + 4) % 4;
            end
            push_level(hold + $urandom_range(0, 2), z);
        end
    endtask

    task automatic drain();
        while (pin_q.size() != 0 || s_tvalid || reading_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [qdx_pkg::CFG_ADDR_W-1:0] addr,
                             logic [qdx_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            qdx_pkg::REG_FILTER_SAMPLES:    fs_cfg = value[qdx_pkg::FS_W-1:0];
            qdx_pkg::REG_DEGREES_PER_COUNT: deg_cfg = value[qdx_pkg::DEG_W-1:0];
            qdx_pkg::REG_INDEX_ENABLE:      idx_en = value[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [qdx_pkg::FS_W-1:0] fs, logic [qdx_pkg::DEG_W-1:0] deg,
                             logic en);
        write_reg(qdx_pkg::REG_FILTER_SAMPLES, qdx_pkg::CFG_DATA_W'(fs));
        write_reg(qdx_pkg::REG_DEGREES_PER_COUNT, qdx_pkg::CFG_DATA_W'(deg));
        write_reg(qdx_pkg::REG_INDEX_ENABLE, qdx_pkg::CFG_DATA_W'(en));
    endtask

    initial begin : stimulus
        int                        n_random;
        int                        n0;
        int                        fs_pick;
        logic [qdx_pkg::DEG_W-1:0] deg_pick;
        bit                        held;
        n_random = 0;
        held     = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // field extremes at the reset settings
        push_pins(0, 0, 0, 0);
        push_pins(1, 1, 1, 1);
        push_pins(1, 0, 0, 0);
        push_pins(0, 1, 0, 0);
        push_pins(0, 0, 1, 0);
        push_pins(0, 0, 0, 1);
        push_pins(0, 0, 0, 0);
        run_encoder(2, int'(qdx_pkg::FILTER_SAMPLES_RST));
        drain();

        write_all(10'd1, DEG_MAX, 1'b1);
        pin_step(0, 0, 0);
        pin_step(0, 0, 0);
        repeat (4) pin_step(1, 0, 0);
        repeat (4) pin_step(-1, 0, 0);
        pin_step(2, 0, 0);
        pin_step(-2, 0, 0);
        pin_step(0, 1, 0);
        // z stays high: no second index, ack clears the flag after this beat
        pin_step(0, 1, 1);
        pin_step(0, 0, 0);
        // index and a count edge in one sample, acked in the same beat
        pin_step(1, 1, 1);
        pin_step(0, 0, 0);
        pin_step(-1, 0, 0);
        pin_step(-1, 0, 0);
        drain();

        while (n_random < 800) begin
            case ($urandom_range(0, 4))
                0: fs_pick = 0;
                1: fs_pick = 1;
                2: fs_pick = 2;
                3: fs_pick = 3;
                default: fs_pick = $urandom_range(4, 12);
            endcase
            case ($urandom_range(0, 3))
                0: deg_pick = '0;
                1: deg_pick = 23'd1;
                2: deg_pick = DEG_MAX;
                default: deg_pick = qdx_pkg::DEG_W'($urandom_range(0, DEG_MAX));
            endcase
            write_all(qdx_pkg::FS_W'(fs_pick), deg_pick, 1'($urandom_range(0, 1)));
            n0 = n_pushed;
            run_encoder($urandom_range(20, 60), fs_pick);
            if (!held) begin
                // long stall on the result side while beats keep coming
                @(posedge aclk);
                sink_hold = 300;
                held = 1'b1;
            end
            drain();
            n_random = n_random + (n_pushed - n0);
        end

        // longest filter, where the run counter tops out
        write_all(FS_MAX, 23'd1, 1'b1);
        run_encoder(1, int'(FS_MAX));
        drain();

        // clear with an index, then run the count up and back down through zero
        write_all(10'd0, DEG_MAX, 1'b1);
        pin_step(0, 0, 0);
        pin_step(0, 1, 0);
        pin_step(0, 0, 0);
        repeat (40) pin_step(1, 0, $urandom_range(0, 1));
        repeat (80) pin_step(-1, 0, 0);
        drain();

        idling_on = 1'b0;
        write_all(10'd2, qdx_pkg::DEG_W'($urandom_range(0, DEG_MAX)), 1'b1);
        run_encoder(40, 2);
        drain();
        repeat (8) @(posedge aclk);

        if (mism == 0 && reading_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
